>>> src/ftd_pkg.sv
// ----------------------------------------------------------------------------
// ftd_pkg - shared types and constants for the decimal ascii formatter
// Stage payload structs, ascii codes and the fraction bit weights.
// ----------------------------------------------------------------------------
package ftd_pkg;

    localparam int VALUE_W     = 16;
    localparam int POS_W       = 4;
    localparam int CHAR_W      = 8;
    localparam int FRAC_BITS   = 12;
    localparam int SUM_W       = 16;
    localparam int FRAC_SRC_W  = SUM_W - 2;
    localparam int INT_DIGITS  = 3;
    localparam int FRAC_DIGITS = 4;
    localparam int ACC_CELLS   = FRAC_BITS;
    localparam int DD_CELLS    = VALUE_W;

    localparam logic [SUM_W-1:0]  FRAC_TOP_WEIGHT     = 16'd20000;
    localparam logic [POS_W-1:0]  THREE_DIGIT_MAX_POS = 4'd5;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;

    typedef struct packed {
        logic [VALUE_W-1:0]   ip;
        logic [FRAC_BITS-1:0] fbits;
        logic [SUM_W-1:0]     fsum;
        logic                 three;
    } ftd_acc_t;

    typedef struct packed {
        logic [VALUE_W-1:0]       ibits;
        logic [4*INT_DIGITS-1:0]  ibcd;
        logic [VALUE_W-1:0]       fsrc;
        logic [4*FRAC_DIGITS-1:0] fbcd;
        logic                     three;
    } ftd_dd_t;

    function automatic logic [SUM_W-1:0] frac_weight(input int idx);
        logic [SUM_W-1:0] w;
        begin
            w = FRAC_TOP_WEIGHT >> idx;
            return w;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] digit);
        return {4'h3, digit};
    endfunction

endpackage

>>> src/ftd_acc_cell.sv
// ----------------------------------------------------------------------------
// ftd_acc_cell - fraction weight accumulate cell
// Adds its bit weight when the top fraction bit is set, then shifts the bits.
// ----------------------------------------------------------------------------
module ftd_acc_cell #(
    parameter logic [ftd_pkg::SUM_W-1:0] WEIGHT = ftd_pkg::FRAC_TOP_WEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  ftd_pkg::ftd_acc_t data_in,
    output logic             valid_out,
    output ftd_pkg::ftd_acc_t data_out
);

    logic              valid_reg;
    ftd_pkg::ftd_acc_t data_reg;
    ftd_pkg::ftd_acc_t data_next;

    always_comb
    begin
        data_next       = data_in;
        data_next.fsum  = data_in.fsum
                        + (data_in.fbits[ftd_pkg::FRAC_BITS-1] ? WEIGHT : '0);
        data_next.fbits = {data_in.fbits[ftd_pkg::FRAC_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> src/ftd_dabble_cell.sv
// ----------------------------------------------------------------------------
// ftd_dabble_cell - one shift-and-add-3 step
// Corrects each bcd digit of both groups and shifts in the next source bit.
// ----------------------------------------------------------------------------
module ftd_dabble_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  ftd_pkg::ftd_dd_t data_in,
    output logic            valid_out,
    output ftd_pkg::ftd_dd_t data_out
);

    logic             valid_reg;
    ftd_pkg::ftd_dd_t data_reg;
    ftd_pkg::ftd_dd_t data_next;
    logic [4*ftd_pkg::INT_DIGITS-1:0]  iadj;
    logic [4*ftd_pkg::FRAC_DIGITS-1:0] fadj;

    always_comb
    begin
        iadj = data_in.ibcd;
        for (int k = 0; k < ftd_pkg::INT_DIGITS; k++)
        begin
            if (data_in.ibcd[4*k +: 4] >= 4'd5)
            begin
                iadj[4*k +: 4] = data_in.ibcd[4*k +: 4] + 4'd3;
            end
        end
        fadj = data_in.fbcd;
        for (int k = 0; k < ftd_pkg::FRAC_DIGITS; k++)
        begin
            if (data_in.fbcd[4*k +: 4] >= 4'd5)
            begin
                fadj[4*k +: 4] = data_in.fbcd[4*k +: 4] + 4'd3;
            end
        end
        // carry out of the top digit is dropped
        data_next       = data_in;
        data_next.ibcd  = {iadj[4*ftd_pkg::INT_DIGITS-2:0],
                           data_in.ibits[ftd_pkg::VALUE_W-1]};
        data_next.ibits = {data_in.ibits[ftd_pkg::VALUE_W-2:0], 1'b0};
        data_next.fbcd  = {fadj[4*ftd_pkg::FRAC_DIGITS-2:0],
                           data_in.fsrc[ftd_pkg::VALUE_W-1]};
        data_next.fsrc  = {data_in.fsrc[ftd_pkg::VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> src/fixed_point_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii - fixed-point value to eight ascii characters
// Fraction weights are summed in a row of accumulate cells, then both digit
// groups go through a row of shift-and-add-3 cells.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------
//   in      | in_valid  | in_stall  | value, point_position
//   out     | out_valid | out_stall | char_0 .. char_7
//
// one item per cycle while the row is not frozen; stages: input register, 12 accumulate
// cells, 16 dabble cells, output register
// the whole row moves together; out_stall on a waiting item freezes every
// stage and raises in_stall in the same cycle
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ftd_pkg::VALUE_W-1:0]   value,
    input  logic [ftd_pkg::POS_W-1:0]     point_position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ftd_pkg::CHAR_W-1:0]    char_0,
    output logic [ftd_pkg::CHAR_W-1:0]    char_1,
    output logic [ftd_pkg::CHAR_W-1:0]    char_2,
    output logic [ftd_pkg::CHAR_W-1:0]    char_3,
    output logic [ftd_pkg::CHAR_W-1:0]    char_4,
    output logic [ftd_pkg::CHAR_W-1:0]    char_5,
    output logic [ftd_pkg::CHAR_W-1:0]    char_6,
    output logic [ftd_pkg::CHAR_W-1:0]    char_7
);

    localparam int NA = ftd_pkg::ACC_CELLS;
    localparam int ND = ftd_pkg::DD_CELLS;

    logic en;

    logic              in_valid_reg;
    ftd_pkg::ftd_acc_t in_data_reg;
    ftd_pkg::ftd_acc_t in_data_next;
    logic [ftd_pkg::VALUE_W-1:0] frac_shift;

    logic              acc_valid [0:NA];
    ftd_pkg::ftd_acc_t acc_data  [0:NA];
    logic              dd_valid  [0:ND];
    ftd_pkg::ftd_dd_t  dd_data   [0:ND];

    logic                       out_valid_reg;
    logic [ftd_pkg::CHAR_W-1:0] chars_reg  [0:7];
    logic [ftd_pkg::CHAR_W-1:0] chars_next [0:7];

    ftd_pkg::ftd_dd_t last;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // a position of zero shifts everything out, so the fraction is zero
    always_comb
    begin
        frac_shift         = value << (5'd16 - {1'b0, point_position});
        in_data_next.ip    = value >> point_position;
        in_data_next.fbits = frac_shift[ftd_pkg::VALUE_W-1 -: ftd_pkg::FRAC_BITS];
        in_data_next.fsum  = '0;
        in_data_next.three = (point_position <= ftd_pkg::THREE_DIGIT_MAX_POS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg  <= in_valid;
            out_valid_reg <= dd_valid[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_data_reg <= in_data_next;
            for (int k = 0; k < 8; k++)
            begin
                chars_reg[k] <= chars_next[k];
            end
        end
    end

    assign acc_valid[0] = in_valid_reg;
    assign acc_data[0]  = in_data_reg;

    for (genvar i = 0; i < NA; i++)
    begin : g_acc
        ftd_acc_cell #(
            .WEIGHT (ftd_pkg::frac_weight(i))
        ) u_acc (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (acc_valid[i]),
            .data_in   (acc_data[i]),
            .valid_out (acc_valid[i+1]),
            .data_out  (acc_data[i+1])
        );
    end

    // fraction digits are the sum divided by four
    always_comb
    begin
        dd_data[0].ibits = acc_data[NA].ip;
        dd_data[0].ibcd  = '0;
        dd_data[0].fsrc  = {2'b00, acc_data[NA].fsum[ftd_pkg::SUM_W-1:2]};
        dd_data[0].fbcd  = '0;
        dd_data[0].three = acc_data[NA].three;
    end
    assign dd_valid[0] = acc_valid[NA];

    for (genvar i = 0; i < ND; i++)
    begin : g_dd
        ftd_dabble_cell u_dd (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dd_valid[i]),
            .data_in   (dd_data[i]),
            .valid_out (dd_valid[i+1]),
            .data_out  (dd_data[i+1])
        );
    end

    assign last = dd_data[ND];

    always_comb
    begin
        if (last.three)
        begin
            chars_next[0] = ftd_pkg::to_ascii(last.ibcd[11:8]);
            chars_next[1] = ftd_pkg::to_ascii(last.ibcd[7:4]);
            chars_next[2] = ftd_pkg::to_ascii(last.ibcd[3:0]);
            chars_next[3] = ftd_pkg::ASCII_POINT;
            chars_next[4] = ftd_pkg::to_ascii(last.fbcd[15:12]);
            chars_next[5] = ftd_pkg::to_ascii(last.fbcd[11:8]);
            chars_next[6] = ftd_pkg::to_ascii(last.fbcd[7:4]);
            chars_next[7] = ftd_pkg::to_ascii(last.fbcd[3:0]);
        end
        else
        begin
            chars_next[0] = ftd_pkg::to_ascii(last.ibcd[7:4]);
            chars_next[1] = ftd_pkg::to_ascii(last.ibcd[3:0]);
            chars_next[2] = ftd_pkg::ASCII_POINT;
            chars_next[3] = ftd_pkg::to_ascii(last.fbcd[15:12]);
            chars_next[4] = ftd_pkg::to_ascii(last.fbcd[11:8]);
            chars_next[5] = ftd_pkg::to_ascii(last.fbcd[7:4]);
            chars_next[6] = ftd_pkg::to_ascii(last.fbcd[3:0]);
            chars_next[7] = ftd_pkg::ASCII_ZERO;
        end
        // leading zero blanking
        if (chars_next[0] == ftd_pkg::ASCII_ZERO)
        begin
            chars_next[0] = ftd_pkg::ASCII_SPACE;
            if (last.three && chars_next[1] == ftd_pkg::ASCII_ZERO)
            begin
                chars_next[1] = ftd_pkg::ASCII_SPACE;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign char_0    = chars_reg[0];
    assign char_1    = chars_reg[1];
    assign char_2    = chars_reg[2];
    assign char_3    = chars_reg[3];
    assign char_4    = chars_reg[4];
    assign char_5    = chars_reg[5];
    assign char_6    = chars_reg[6];
    assign char_7    = chars_reg[7];

endmodule

>>> src/ftd_checker.sv
// ----------------------------------------------------------------------------
// ftd_checker - port checks for the decimal ascii formatter
// Watches the handshakes and the character layout on the top level ports.
// ----------------------------------------------------------------------------
module ftd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ftd_pkg::CHAR_W-1:0]    char_0,
    input logic [ftd_pkg::CHAR_W-1:0]    char_1,
    input logic [ftd_pkg::CHAR_W-1:0]    char_2,
    input logic [ftd_pkg::CHAR_W-1:0]    char_3,
    input logic [ftd_pkg::CHAR_W-1:0]    char_4,
    input logic [ftd_pkg::CHAR_W-1:0]    char_5,
    input logic [ftd_pkg::CHAR_W-1:0]    char_6,
    input logic [ftd_pkg::CHAR_W-1:0]    char_7
);

    // input is held back only by a waiting result
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the waiting result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(char_0)
            && $stable(char_3) && $stable(char_7)))
        else $error("stalled result changed");

    // exactly one point, in third or fourth place
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char_2 == ftd_pkg::ASCII_POINT)
                       != (char_3 == ftd_pkg::ASCII_POINT)))
        else $error("point misplaced");

    a_two_digit_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_2 == ftd_pkg::ASCII_POINT)
            |-> (char_7 == ftd_pkg::ASCII_ZERO))
        else $error("two digit layout lacks trailing zero");

endmodule

bind fixed_point_to_decimal_ascii ftd_checker u_ftd_checker (.*);
